// ===== rtl/core/rotation_matrix_to_quaternion_q12_core_assert.svh =====
// assertion macros for the matrix to quaternion core
// sampled on clk; the first form is gated by reset, the second is not
`ifndef ROTATION_MATRIX_TO_QUATERNION_Q12_CORE_ASSERT_SVH
`define ROTATION_MATRIX_TO_QUATERNION_Q12_CORE_ASSERT_SVH

// property checked outside reset
`define RMQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked at every edge, reset included
`define RMQ_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/core/rmq_pkg.sv =====
// ----------------------------------------------------------------------------
// rmq_pkg
// Shared widths, codes and item types of the matrix to quaternion core.
// ----------------------------------------------------------------------------
package rmq_pkg;

  // default fraction bits of the fixed-point format
  localparam int FRAC_BITS_DEF = 12;
  // matrix entry, difference, radicand and result widths
  localparam int M_W   = 14;
  localparam int D_W   = 15;
  localparam int RAD_W = 18;
  localparam int OUT_W = 16;
  // depth of the queue between classifier and datapath
  localparam int QUEUE_DEPTH = 4;

  // output component that takes the halved square root
  typedef enum logic [1:0] {
    SLOT_W = 2'd0,
    SLOT_X = 2'd1,
    SLOT_Y = 2'd2,
    SLOT_Z = 2'd3
  } slot_t;

  // payload carried alongside the square root and reciprocal
  typedef struct packed {
    logic                  degen;
    slot_t                 slot;
    logic [3:0][D_W-1:0]   d;
  } sq_pay_t;

  // classified word handed from front to back
  typedef struct packed {
    logic [RAD_W-1:0] rad;
    sq_pay_t          pay;
  } front_item_t;

endpackage

// ===== rtl/core/rmq_if.sv =====
// ----------------------------------------------------------------------------
// rmq_in_if / rmq_out_if
// Valid/ready channels carrying a matrix word in and a quaternion word out.
// ----------------------------------------------------------------------------
interface rmq_in_if;
  import rmq_pkg::*;

  logic                  valid;
  logic                  ready;
  logic signed [M_W-1:0] m00;
  logic signed [M_W-1:0] m01;
  logic signed [M_W-1:0] m02;
  logic signed [M_W-1:0] m10;
  logic signed [M_W-1:0] m11;
  logic signed [M_W-1:0] m12;
  logic signed [M_W-1:0] m20;
  logic signed [M_W-1:0] m21;
  logic signed [M_W-1:0] m22;

  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

interface rmq_out_if;
  import rmq_pkg::*;

  logic                    valid;
  logic                    ready;
  logic signed [OUT_W-1:0] quat_w;
  logic signed [OUT_W-1:0] quat_x;
  logic signed [OUT_W-1:0] quat_y;
  logic signed [OUT_W-1:0] quat_z;
  logic                    degenerate;

  modport source (output valid, quat_w, quat_x, quat_y, quat_z, degenerate,
                  input ready);
  modport sink   (input valid, quat_w, quat_x, quat_y, quat_z, degenerate,
                  output ready);
endinterface

// ===== rtl/core/rotation_matrix_to_quaternion_q12_core.sv =====
// ----------------------------------------------------------------------------
// rotation_matrix_to_quaternion_q12_core
// Rotation matrix to quaternion by Shepperd's method in Q fixed point.
//
//   channel  dir  handshake        word
//   in_ch    in   valid / ready    m00 .. m22, 14-bit signed
//   out_ch   out  valid / ready    quat_w .. quat_z 16-bit signed, degenerate
//
// One word per cycle sustained while out_ch takes words. From the accepting
// edge a word passes the classifier register, the queue, the square root
// stages (ROOT_W, 15 at 12 fraction bits), the reciprocal stages (FRAC_BITS
// + 32) and the multiply and output registers; the divide pipe is the longest.
// Synchronous active-low reset clears all valid bits; no clearing pass.
// A held output word freezes the datapath; the queue and the classifier
// register absorb up to five words before in_ch.ready drops.
// ----------------------------------------------------------------------------
module rotation_matrix_to_quaternion_q12_core #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  rmq_in_if.sink     in_ch,
  rmq_out_if.source  out_ch
);
  import rmq_pkg::*;

  logic        q_push, q_full, q_empty, q_pop;
  front_item_t q_wr_item, q_rd_item;
  logic        quat_zero;

  rmq_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (q_wr_item)
  );

  rmq_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .wr_item (q_wr_item),
    .pop     (q_pop),
    .empty   (q_empty),
    .full    (q_full),
    .rd_item (q_rd_item)
  );

  rmq_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_v    (!q_empty),
    .in_item (q_rd_item),
    .pop     (q_pop),
    .out_ch  (out_ch)
  );

  // all four components zero
  assign quat_zero = (out_ch.quat_w == '0) && (out_ch.quat_x == '0) &&
                     (out_ch.quat_y == '0) && (out_ch.quat_z == '0);

`include "rotation_matrix_to_quaternion_q12_core_assert.svh"

  `RMQ_ASSERT(a_degen_zero, out_ch.valid && out_ch.degenerate |-> quat_zero, "degenerate word with nonzero component")
  `RMQ_ASSERT(a_queue_no_overflow, q_full |-> !q_push, "push into full queue")
  `RMQ_ASSERT(a_stall_blocks_input, !in_ch.ready |-> q_full, "input stalled while queue has room")
  `RMQ_ASSERT_ALWAYS(a_reset_idle, !rst_n |=> !out_ch.valid, "output valid after reset")

endmodule

// ===== rtl/core/rmq_front.sv =====
// ----------------------------------------------------------------------------
// rmq_front
// Accepts a matrix word, picks the branch and axis, forms the radicand and
// the off-diagonal sums and differences, and pushes the result to the queue.
// ----------------------------------------------------------------------------
module rmq_front #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  rmq_in_if.sink              in_ch,
  input  logic                q_full,
  output logic                q_push,
  output rmq_pkg::front_item_t q_item
);
  import rmq_pkg::*;

  localparam int E_W = 20;
  localparam logic signed [E_W-1:0] ONE = E_W'(1) << FRAC_BITS;

  logic signed [E_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
  logic signed [E_W-1:0] trace, mii, mjj, mkk, rad;
  logic                  pos;
  logic [1:0]            axis;
  front_item_t           item_nxt, item_r;
  logic                  v_r;
  logic                  accept;

  // sign-extend entries
  assign e00 = E_W'(in_ch.m00);
  assign e01 = E_W'(in_ch.m01);
  assign e02 = E_W'(in_ch.m02);
  assign e10 = E_W'(in_ch.m10);
  assign e11 = E_W'(in_ch.m11);
  assign e12 = E_W'(in_ch.m12);
  assign e20 = E_W'(in_ch.m20);
  assign e21 = E_W'(in_ch.m21);
  assign e22 = E_W'(in_ch.m22);

  // branch, axis and radicand
  always_comb begin
    trace = e00 + e11 + e22;
    pos   = trace > 0;
    axis  = 2'd0;
    if (e11 > e00) axis = 2'd1;
    case (axis)
      2'd1:    if (e22 > e11) axis = 2'd2;
      default: if (e22 > e00) axis = 2'd2;
    endcase
    case (axis)
      2'd1:    begin mii = e11; mjj = e22; mkk = e00; end
      2'd2:    begin mii = e22; mjj = e00; mkk = e11; end
      default: begin mii = e00; mjj = e11; mkk = e22; end
    endcase
    rad = pos ? trace + ONE : mii - mjj - mkk + ONE;
  end

  // sums and differences by output slot
  always_comb begin
    item_nxt.pay.degen = rad <= 0;
    item_nxt.rad       = item_nxt.pay.degen ? '0 : rad[RAD_W-1:0];
    item_nxt.pay.d     = '0;
    if (pos) begin
      item_nxt.pay.slot = SLOT_W;
      item_nxt.pay.d[1] = D_W'(e12 - e21);
      item_nxt.pay.d[2] = D_W'(e20 - e02);
      item_nxt.pay.d[3] = D_W'(e01 - e10);
    end else begin
      case (axis)
        2'd1: begin
          item_nxt.pay.slot = SLOT_Y;
          item_nxt.pay.d[0] = D_W'(e20 - e02);
          item_nxt.pay.d[3] = D_W'(e12 + e21);
          item_nxt.pay.d[1] = D_W'(e10 + e01);
        end
        2'd2: begin
          item_nxt.pay.slot = SLOT_Z;
          item_nxt.pay.d[0] = D_W'(e01 - e10);
          item_nxt.pay.d[1] = D_W'(e20 + e02);
          item_nxt.pay.d[2] = D_W'(e21 + e12);
        end
        default: begin
          item_nxt.pay.slot = SLOT_X;
          item_nxt.pay.d[0] = D_W'(e12 - e21);
          item_nxt.pay.d[2] = D_W'(e01 + e10);
          item_nxt.pay.d[3] = D_W'(e02 + e20);
        end
      endcase
    end
  end

  // holding register toward the queue
  assign q_push      = v_r && !q_full;
  assign in_ch.ready = !v_r || !q_full;
  assign accept      = in_ch.valid && in_ch.ready;
  assign q_item      = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (accept) begin
      v_r <= 1'b1;
    end else if (q_push) begin
      v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_r <= item_nxt;
    end
  end

endmodule

// ===== rtl/core/rmq_queue.sv =====
// ----------------------------------------------------------------------------
// rmq_queue
// Small register queue of classified words between front and back.
// ----------------------------------------------------------------------------
module rmq_queue #(
  parameter int DEPTH = rmq_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  rmq_pkg::front_item_t wr_item,
  input  logic                 pop,
  output logic                 empty,
  output logic                 full,
  output rmq_pkg::front_item_t rd_item
);
  import rmq_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  front_item_t        mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   cnt_r;
  logic               do_pop;

  assign empty   = cnt_r == '0;
  assign full    = cnt_r == CNT_W'(DEPTH);
  assign do_pop  = pop && !empty;
  assign rd_item = mem_r[rd_ptr_r];

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !do_pop) begin
        cnt_r <= cnt_r + 1'b1;
      end else if (do_pop && !push) begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

// ===== rtl/core/rmq_sqrt.sv =====
// ----------------------------------------------------------------------------
// rmq_sqrt
// Pipelined digit-by-digit square root of rad << FRAC_BITS, one root bit
// per stage, with the word payload riding along.
// ----------------------------------------------------------------------------
module rmq_sqrt #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
  localparam int SQ_IN_W  = rmq_pkg::RAD_W + FRAC_BITS + (FRAC_BITS % 2),
  localparam int ROOT_W   = SQ_IN_W / 2
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_v,
  input  logic [rmq_pkg::RAD_W-1:0] in_rad,
  input  rmq_pkg::sq_pay_t         in_pay,
  output logic                     out_v,
  output logic [ROOT_W-1:0]        out_root,
  output rmq_pkg::sq_pay_t         out_pay
);
  import rmq_pkg::*;

  localparam int REM_W = ROOT_W + 2;

  logic [REM_W-1:0]   rem_r  [ROOT_W+1];
  logic [ROOT_W-1:0]  root_r [ROOT_W+1];
  logic [SQ_IN_W-1:0] rad_r  [ROOT_W+1];
  sq_pay_t            pay_r  [ROOT_W+1];
  logic               v_r    [ROOT_W+1];

  // stage zero inputs
  assign rem_r[0]  = '0;
  assign root_r[0] = '0;
  assign rad_r[0]  = {{(SQ_IN_W-RAD_W){1'b0}}, in_rad} << FRAC_BITS;
  assign pay_r[0]  = in_pay;
  assign v_r[0]    = in_v;

  for (genvar s = 0; s < ROOT_W; s++) begin : g_stage
    logic [REM_W-1:0] rem_sh, trial;
    logic             ge;

    // try the next root bit
    assign rem_sh = {rem_r[s][REM_W-3:0], rad_r[s][SQ_IN_W-1 -: 2]};
    assign trial  = {root_r[s], 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[s+1] <= 1'b0;
      end else if (en) begin
        v_r[s+1] <= v_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s+1]  <= ge ? rem_sh - trial : rem_sh;
        root_r[s+1] <= {root_r[s][ROOT_W-2:0], ge};
        rad_r[s+1]  <= rad_r[s] << 2;
        pay_r[s+1]  <= pay_r[s];
      end
    end
  end

  assign out_v    = v_r[ROOT_W];
  assign out_root = root_r[ROOT_W];
  assign out_pay  = pay_r[ROOT_W];

endmodule

// ===== rtl/core/rmq_div.sv =====
// ----------------------------------------------------------------------------
// rmq_div
// Pipelined restoring divide of half << 32 by the root, one quotient bit
// per stage, giving the truncated Q32 reciprocal.
// ----------------------------------------------------------------------------
module rmq_div #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF,
  parameter int DIV_W     = 15,
  localparam int Q_W      = FRAC_BITS + 32
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  logic             in_v,
  input  logic [DIV_W-1:0] in_dvs,
  input  rmq_pkg::sq_pay_t in_pay,
  output logic             out_v,
  output logic [Q_W-1:0]   out_q,
  output logic [DIV_W-1:0] out_dvs,
  output rmq_pkg::sq_pay_t out_pay
);
  import rmq_pkg::*;

  logic [DIV_W:0]   rem_r [Q_W+1];
  logic [Q_W-1:0]   q_r   [Q_W+1];
  logic [DIV_W-1:0] dvs_r [Q_W+1];
  sq_pay_t          pay_r [Q_W+1];
  logic             v_r   [Q_W+1];

  assign rem_r[0] = '0;
  assign q_r[0]   = '0;
  assign dvs_r[0] = in_dvs;
  assign pay_r[0] = in_pay;
  assign v_r[0]   = in_v;

  for (genvar t = 0; t < Q_W; t++) begin : g_stage
    // the dividend has its single set bit at the top quotient position
    localparam logic NUM_BIT = (t == 0);
    logic [DIV_W:0] rem_sh, dvs_x;
    logic           ge;

    assign rem_sh = {rem_r[t][DIV_W-1:0], NUM_BIT};
    assign dvs_x  = {1'b0, dvs_r[t]};
    assign ge     = rem_sh >= dvs_x;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[t+1] <= 1'b0;
      end else if (en) begin
        v_r[t+1] <= v_r[t];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[t+1] <= ge ? rem_sh - dvs_x : rem_sh;
        q_r[t+1]   <= {q_r[t][Q_W-2:0], ge};
        dvs_r[t+1] <= dvs_r[t];
        pay_r[t+1] <= pay_r[t];
      end
    end
  end

  assign out_v   = v_r[Q_W];
  assign out_q   = q_r[Q_W];
  assign out_dvs = dvs_r[Q_W];
  assign out_pay = pay_r[Q_W];

endmodule

// ===== rtl/core/rmq_back.sv =====
// ----------------------------------------------------------------------------
// rmq_back
// Datapath: square root, reciprocal, four products, rounding, saturation
// and the output register. All stages advance together unless the output
// word is held.
// ----------------------------------------------------------------------------
module rmq_back #(
  parameter int FRAC_BITS = rmq_pkg::FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_v,
  input  rmq_pkg::front_item_t in_item,
  output logic                 pop,
  rmq_out_if.source            out_ch
);
  import rmq_pkg::*;

  localparam int SQ_IN_W = RAD_W + FRAC_BITS + (FRAC_BITS % 2);
  localparam int ROOT_W  = SQ_IN_W / 2;
  localparam int Q_W     = FRAC_BITS + 32;
  localparam int P_W     = Q_W + 1 + D_W;
  localparam int H_W     = P_W - 32;
  localparam logic signed [P_W-1:0] RND_C = P_W'(64'h8000_0000);
  localparam logic signed [H_W-1:0] MAX_V = H_W'(32767);
  localparam logic signed [H_W-1:0] MIN_V = -H_W'(32768);

  logic                    en;
  logic                    sq_v, dv_v;
  logic [ROOT_W-1:0]       root, dvs;
  sq_pay_t                 sq_pay, dv_pay, mul_pay_r;
  logic [Q_W-1:0]          recip;
  logic signed [P_W-1:0]   prod_r [4];
  logic [OUT_W-1:0]        half_r;
  logic                    mul_v_r;
  logic signed [OUT_W-1:0] comp [4];
  logic signed [OUT_W-1:0] out_q_r [4];
  logic                    out_degen_r, out_v_r;

  // whole datapath moves unless a finished word is held
  assign en  = !out_v_r || out_ch.ready;
  assign pop = en;

  rmq_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_v     (in_v),
    .in_rad   (in_item.rad),
    .in_pay   (in_item.pay),
    .out_v    (sq_v),
    .out_root (root),
    .out_pay  (sq_pay)
  );

  rmq_div #(.FRAC_BITS(FRAC_BITS), .DIV_W(ROOT_W)) u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_v    (sq_v),
    .in_dvs  (root),
    .in_pay  (sq_pay),
    .out_v   (dv_v),
    .out_q   (recip),
    .out_dvs (dvs),
    .out_pay (dv_pay)
  );

  // products of reciprocal and sums/differences, halved root saturated
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
    end else if (en) begin
      mul_v_r <= dv_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < 4; n++) begin
        prod_r[n] <= $signed({1'b0, recip}) * $signed(dv_pay.d[n]);
      end
      half_r    <= (32'(dvs >> 1) > 32'd32767) ? OUT_W'(32767) : OUT_W'(dvs >> 1);
      mul_pay_r <= dv_pay;
    end
  end

  // round to nearest on the high word, then saturate; degenerate words give zero, the slot takes the halved root
  always_comb begin
    for (int n = 0; n < 4; n++) begin
      logic signed [P_W-1:0] rnd;
      logic signed [H_W-1:0] hi;
      rnd = prod_r[n] + RND_C;
      hi  = $signed(rnd[P_W-1:32]);
      if (mul_pay_r.degen) begin
        comp[n] = '0;
      end else if (mul_pay_r.slot == slot_t'(n)) begin
        comp[n] = $signed(half_r);
      end else if (hi > MAX_V) begin
        comp[n] = OUT_W'(32767);
      end else if (hi < MIN_V) begin
        comp[n] = -OUT_W'(32768);
      end else begin
        comp[n] = OUT_W'(hi);
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= mul_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int n = 0; n < 4; n++) begin
        out_q_r[n] <= comp[n];
      end
      out_degen_r <= mul_pay_r.degen;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.quat_w     = out_q_r[0];
  assign out_ch.quat_x     = out_q_r[1];
  assign out_ch.quat_y     = out_q_r[2];
  assign out_ch.quat_z     = out_q_r[3];
  assign out_ch.degenerate = out_degen_r;

endmodule
